>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 gray morphology stream.
// Needs nothing else; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GM3_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define GM3_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define GM3_ASSERT_IMP(label, ck, rn, ante, cons)

`define GM3_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

>>> design/gm3_pkg.sv
// Package of the 3x3 gray morphology stream: constants, codes and types.
// Has no dependencies; the interfaces, gm3_window, gm3_out_fifo and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package gm3_pkg;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int MAX_ROWS       = 4096;

  localparam int IO_PIX_W   = 8;
  localparam int COLS_REG_W = 11;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_DEPTH  = 4;

  localparam int RST_COLS = 640;
  localparam int RST_ROWS = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_MORPH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

  localparam logic FUNC_DRAIN = 1'b1;
  localparam logic MODE_ERODE = 1'b1;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } gm3_tag_t;

  typedef struct packed {
    logic [IO_PIX_W-1:0] pixel_out;
    logic                frame_last;
  } gm3_result_t;

endpackage

`default_nettype wire

>>> design/gm3_in_if.sv
// Input channel of the 3x3 gray morphology stream: valid, ready and payload.
// Depends on gm3_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

interface gm3_in_if;
  import gm3_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [IO_PIX_W-1:0] pixel_in;

  modport source (output valid, output func, output pixel_in, input ready);
  modport sink (input valid, input func, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> design/gm3_out_if.sv
// Result channel of the 3x3 gray morphology stream: valid, ready and payload.
// Depends on gm3_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

interface gm3_out_if;
  import gm3_pkg::*;

  logic                valid;
  logic                ready;
  logic [IO_PIX_W-1:0] pixel_out;
  logic                frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

>>> design/gm3_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the line buffers of the morphology stream.
`timescale 1ns / 1ps
`default_nettype none

module gm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;
endmodule

`default_nettype wire

>>> design/gm3_window.sv
// 3x3 window registers and the nine-way maximum or minimum behind them.
// Depends on gm3_pkg for the tag and result types.
`timescale 1ns / 1ps
`default_nettype none

module gm3_window #(
  parameter int PIXEL_BITS = gm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic                   shift,
  input  logic [PIXEL_BITS-1:0]  col_up,
  input  logic [PIXEL_BITS-1:0]  col_lo,
  input  logic [PIXEL_BITS-1:0]  col_px,
  input  gm3_pkg::gm3_tag_t      tag_in,
  input  logic                   mode,
  output logic                   res_valid,
  output gm3_pkg::gm3_result_t   res
);
  import gm3_pkg::*;

  logic [PIXEL_BITS-1:0] win_r [3][3];
  logic                  s2_valid_r;
  gm3_tag_t              s2_tag_r;

  logic [PIXEL_BITS-1:0]          m0, m1, m2, m3, n0, n1, o0, red, sel;
  logic [PIXEL_BITS+IO_PIX_W-1:0] sel_ext;

  function automatic logic [PIXEL_BITS-1:0] pick(
    input logic [PIXEL_BITS-1:0] a,
    input logic [PIXEL_BITS-1:0] b,
    input logic                  erode
  );
    logic take_b;
    take_b = (erode == MODE_ERODE) ? (b < a) : (b > a);
    return take_b ? b : a;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
      s2_valid_r <= 1'b0;
    end else begin
      if (shift) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= col_up;
        win_r[1][2] <= col_lo;
        win_r[2][2] <= col_px;
      end
      s2_valid_r <= shift && tag_in.emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_tag_r <= tag_in;
  end

  always_comb begin
    m0  = pick(win_r[0][0], win_r[0][1], mode);
    m1  = pick(win_r[0][2], win_r[1][0], mode);
    m2  = pick(win_r[1][1], win_r[1][2], mode);
    m3  = pick(win_r[2][0], win_r[2][1], mode);
    n0  = pick(m0, m1, mode);
    n1  = pick(m2, m3, mode);
    o0  = pick(n0, n1, mode);
    red = pick(o0, win_r[2][2], mode);
    sel = s2_tag_r.interior ? red : win_r[1][1];
    sel_ext = {{IO_PIX_W{1'b0}}, sel};
  end

  assign res_valid      = s2_valid_r;
  assign res.pixel_out  = sel_ext[IO_PIX_W-1:0];
  assign res.frame_last = s2_tag_r.last;
endmodule

`default_nettype wire

>>> design/gm3_out_fifo.sv
// Small result queue that drives the output channel of the morphology stream.
// Depends on gm3_pkg and the gm3_out_if interface.
`timescale 1ns / 1ps
`default_nettype none

module gm3_out_fifo #(
  parameter int DEPTH = gm3_pkg::OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  gm3_pkg::gm3_result_t       push_data,
  gm3_out_if.source                  out_chan,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import gm3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  gm3_result_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  assign out_chan.valid      = (count_r != '0);
  assign out_chan.pixel_out  = mem_r[rd_ptr_r].pixel_out;
  assign out_chan.frame_last = mem_r[rd_ptr_r].frame_last;
  assign count               = count_r;
endmodule

`default_nettype wire

>>> design/gray_morphology_3x3_stream_top.sv
// Top level of the 3x3 gray morphology stream: raster counters, line buffer
// RAM with forwarding, window and result queue. Depends on gm3_pkg, the
// channel interfaces, gm3_ram, gm3_window, gm3_out_fifo and assert_macros.svh.
//
//   channel   direction   handshake          payload
//   in_chan   in          valid / ready      func, pixel_in
//   out_chan  out         valid / ready      pixel_out, frame_last
//   cfg_*     in          cfg_we only        cfg_index, cfg_wdata
//
// One transaction per clock in steady state while in_chan.ready is high; a
// taken transaction's result passes the line buffer read, window and queue.
// The line buffer RAM is read every cycle and written for each transaction
// taken and not skipped; a read of a column that is being written is forwarded,
// so columns of one pixel run at full rate too. in_chan.ready drops only when
// the four-entry result queue and the results in flight would overflow it.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gray_morphology_3x3_stream_top #(
  parameter int MAX_COLS   = gm3_pkg::DEF_MAX_COLS,
  parameter int PIXEL_BITS = gm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gm3_in_if.sink                         in_chan,
  gm3_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [gm3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gm3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gm3_pkg::*;

  localparam int COL_W        = $clog2(MAX_COLS);
  localparam int CNT_W        = COL_W + 1;
  localparam int TOT_W        = CNT_W + ROW_W;
  localparam int CMP_W        = (CNT_W > COLS_REG_W) ? CNT_W : COLS_REG_W;
  localparam int RST_COLS_EFF = (RST_COLS > MAX_COLS) ? MAX_COLS : RST_COLS;
  localparam int QCNT_W       = $clog2(OUT_DEPTH+1);
  localparam int OCC_W        = QCNT_W + 1;

  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] cols_r, cols_nxt, cols_sat;
  logic [ROW_W-1:0] rows_r, rows_nxt, rows_sat;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [CMP_W-1:0] cols_raw;
  logic             restart;

  always_comb begin
    cols_raw = CMP_W'(cfg_wdata[COLS_REG_W-1:0]);
    priority if (cols_raw == '0) begin
      cols_sat = CNT_W'(1);
    end else if (cols_raw > CMP_W'(MAX_COLS)) begin
      cols_sat = CNT_W'(MAX_COLS);
    end else begin
      cols_sat = cols_raw[CNT_W-1:0];
    end
    priority if (cfg_wdata == '0) begin
      rows_sat = ROW_W'(1);
    end else if (cfg_wdata > CFG_DATA_W'(MAX_ROWS)) begin
      rows_sat = ROW_W'(MAX_ROWS);
    end else begin
      rows_sat = ROW_W'(cfg_wdata);
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    restart  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MORPH_MODE: mode_nxt = cfg_wdata[0];
        CFG_IMAGE_COLS: begin
          cols_nxt = cols_sat;
          restart  = 1'b1;
        end
        CFG_IMAGE_ROWS: begin
          rows_nxt = rows_sat;
          restart  = 1'b1;
        end
        default: ;
      endcase
    end
    total_nxt = TOT_W'({{ROW_W{1'b0}}, cols_nxt} * {{CNT_W{1'b0}}, rows_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      cols_r  <= CNT_W'(RST_COLS_EFF);
      rows_r  <= ROW_W'(RST_ROWS);
      total_r <= TOT_W'(RST_COLS_EFF * RST_ROWS);
    end else begin
      mode_r  <= mode_nxt;
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
      total_r <= total_nxt;
    end
  end

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [TOT_W-1:0] out_cnt_r, out_cnt_nxt, oc_inc;
  logic [CNT_W-1:0] col_inc;
  logic             accept, receiving, skip, act, col_wrap;
  gm3_tag_t         tag0;

  logic [PIXEL_BITS+IO_PIX_W-1:0] px_ext;
  logic [PIXEL_BITS-1:0]          px0;

  assign accept    = in_chan.valid && in_chan.ready;
  assign receiving = in_row_r < rows_r;
  assign skip      = (in_chan.func == FUNC_DRAIN) && receiving;
  assign act       = accept && !skip;
  assign px_ext    = {{PIXEL_BITS{1'b0}}, in_chan.pixel_in};
  assign px0       = receiving ? px_ext[PIXEL_BITS-1:0] : '0;
  assign col_inc   = CNT_W'(in_col_r) + 1'b1;
  assign col_wrap  = col_inc >= cols_r;
  assign oc_inc    = out_cnt_r + 1'b1;

  always_comb begin
    tag0.emit     = (in_row_r >= ROW_W'(2)) ||
                    ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    tag0.interior = (in_row_r >= ROW_W'(2)) && receiving &&
                    (in_col_r >= COL_W'(2));
    tag0.last     = oc_inc >= total_r;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_cnt_nxt = out_cnt_r;
    priority if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_cnt_nxt = '0;
    end else if (act && tag0.emit && tag0.last) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_cnt_nxt = '0;
    end else if (act) begin
      in_col_nxt  = col_wrap ? '0 : col_inc[COL_W-1:0];
      in_row_nxt  = col_wrap ? in_row_r + 1'b1 : in_row_r;
      out_cnt_nxt = tag0.emit ? oc_inc : out_cnt_r;
    end else begin
      in_col_nxt  = in_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  logic                    s1_valid_r;
  logic [COL_W-1:0]        s1_col_r;
  logic [PIXEL_BITS-1:0]   s1_px_r;
  gm3_tag_t                s1_tag_r;
  logic                    fwd_r;
  logic [PIXEL_BITS-1:0]   fwd_up_r, fwd_lo_r;
  logic [PIXEL_BITS-1:0]   s1_up, s1_lo;
  logic [2*PIXEL_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= act;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r <= in_col_r;
    s1_px_r  <= px0;
    s1_tag_r <= tag0;
    fwd_r    <= s1_valid_r && (s1_col_r == in_col_r);
    fwd_up_r <= s1_lo;
    fwd_lo_r <= s1_px_r;
  end

  assign s1_up = fwd_r ? fwd_up_r : ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign s1_lo = fwd_r ? fwd_lo_r : ram_rdata[PIXEL_BITS-1:0];

  gm3_ram #(
    .WIDTH (2*PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .we      (s1_valid_r),
    .waddr   (s1_col_r),
    .wdata   ({s1_lo, s1_px_r}),
    .raddr   (in_col_r),
    .rd_data (ram_rdata)
  );

  logic              res_valid;
  gm3_result_t       res;
  logic [QCNT_W-1:0] q_count;
  logic [OCC_W-1:0]  occupancy;

  gm3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (restart),
    .shift     (s1_valid_r),
    .col_up    (s1_up),
    .col_lo    (s1_lo),
    .col_px    (s1_px_r),
    .tag_in    (s1_tag_r),
    .mode      (mode_r),
    .res_valid (res_valid),
    .res       (res)
  );

  gm3_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_chan  (out_chan),
    .count     (q_count)
  );

  assign occupancy = OCC_W'(q_count) + OCC_W'(s1_valid_r && s1_tag_r.emit) +
                     OCC_W'(res_valid);
  assign in_chan.ready = occupancy < OCC_W'(OUT_DEPTH);

  `GM3_ASSERT_IMP(a_col_in_range, clk, rst_n, 1'b1, CNT_W'(in_col_r) < cols_r)
  `GM3_ASSERT_IMP(a_out_cnt_in_range, clk, rst_n, 1'b1, out_cnt_r < total_r)
  `GM3_ASSERT_NEXT(a_drain_held, clk, rst_n, accept && skip, !s1_valid_r)
  `GM3_ASSERT_IMP(a_queue_credit, clk, rst_n, 1'b1, occupancy <= OCC_W'(OUT_DEPTH))
endmodule

`default_nettype wire
